// ----- sv/rks_pkg.sv -----
package rks_pkg;

    typedef struct packed {
        logic signed [31:0] record_key;
        logic        [31:0] record_id;
        logic               last_record;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] sorted_key;
        logic        [31:0] sorted_id;
        logic               last_out;
        logic               overflowed;
    } t_out_item;

    // one stored record inside the chain
    typedef struct packed {
        logic signed [31:0] key;
        logic        [31:0] id;
    } t_rec;

    // chain-wide control, the same for every cell
    typedef struct packed {
        logic load;
        logic emit;
    } t_cell_ctl;

endpackage

// ----- sv/rks_cell.sv -----
module rks_cell
    import rks_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_rec      i_new,
    input  logic      i_empty,
    input  t_rec      i_left,
    input  logic      i_left_place,
    input  t_rec      i_right,
    output t_rec      o_rec,
    output logic      o_place
);

    t_rec r_rec;
    t_rec n_rec;

    // the new record belongs here or further left: slot free, or stored key is larger
    assign o_place = i_empty || ($signed(r_rec.key) > $signed(i_new.key));

    always_comb begin
        n_rec = r_rec;
        if (i_ctl.emit) begin
            n_rec = i_right;
        end else if (i_ctl.load && o_place) begin
            n_rec = i_left_place ? i_left : i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec = r_rec;

endmodule

// ----- sv/record_key_sorter_core.sv -----
// channel | direction | handshake                  | payload
// input   | in        | i_in_valid / o_in_ready    | i_in_item  (t_in_item)
// output  | out       | o_out_valid / i_out_ready  | o_out_item (t_out_item)
//
// Loading takes one record per cycle; every cell compares the broadcast key at once
// and the chain shifts right by one behind the insertion point.
// The transaction with last_record set moves the block to emission: one result per
// cycle leaves cell 0 while i_out_ready is high, and the chain shifts left;
// o_in_ready is low until the final result is accepted.
// A set of n transactions yields min(n, MAX_RECORDS) results.
// Synchronous reset clears the fill count, the drop flag and the state; no clearing pass.
// A record arriving with all MAX_RECORDS cells filled is dropped and flags the run.
module record_key_sorter_core
    import rks_pkg::*;
#(
    parameter int MAX_RECORDS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic             r_state;
    logic             n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_ovf;
    logic             n_ovf;

    logic      w_in_acc;
    logic      w_out_acc;
    logic      w_full;
    t_cell_ctl w_ctl;
    t_rec      w_new;
    t_rec      w_rec   [MAX_RECORDS];
    logic      w_place [MAX_RECORDS];

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;
    assign w_full    = (r_count == CNT_W'(MAX_RECORDS));

    assign o_in_ready  = (r_state == ST_LOAD);
    assign o_out_valid = (r_state == ST_EMIT);

    assign w_new.key = i_in_item.record_key;
    assign w_new.id  = i_in_item.record_id;

    // drop the record when the chain is full
    assign w_ctl.load = w_in_acc && !w_full;
    assign w_ctl.emit = w_out_acc;

    for (genvar g = 0; g < MAX_RECORDS; g++) begin : g_cell
        t_rec w_left;
        logic w_left_place;
        t_rec w_right;

        if (g == 0) begin : g_head
            assign w_left       = '0;
            assign w_left_place = 1'b0;
        end else begin : g_mid
            assign w_left       = w_rec[g-1];
            assign w_left_place = w_place[g-1];
        end

        if (g == MAX_RECORDS - 1) begin : g_tail
            assign w_right = w_rec[g];
        end else begin : g_body
            assign w_right = w_rec[g+1];
        end

        rks_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_new        (w_new),
            .i_empty      (CNT_W'(g) >= r_count),
            .i_left       (w_left),
            .i_left_place (w_left_place),
            .i_right      (w_right),
            .o_rec        (w_rec[g]),
            .o_place      (w_place[g])
        );
    end

    assign o_out_item.sorted_key = w_rec[0].key;
    assign o_out_item.sorted_id  = w_rec[0].id;
    assign o_out_item.last_out   = (r_count == CNT_W'(1));
    assign o_out_item.overflowed = r_ovf;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ovf   = r_ovf;
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_acc) begin
                    if (w_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                    if (i_in_item.last_record) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (w_out_acc) begin
                    n_count = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_state = ST_LOAD;
                        n_ovf   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_count != '0))
        else $error("emission with an empty chain");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RECORDS))
        else $error("fill count beyond capacity");

    a_drop_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_full) |=> r_ovf)
        else $error("dropped record not flagged");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_out_item.last_out) |=> (o_in_ready && !r_ovf && r_count == '0))
        else $error("block not cleared after final result");

endmodule

// ----- dv/record_key_sorter_core_chk.sv -----
module record_key_sorter_core_chk
    import rks_pkg::*;
#(
    parameter int MAX_RECORDS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_records_due
);
    timeunit 1ns;
    timeprecision 1ps;

    t_rec      held_set[$];
    logic      set_dropped;
    t_out_item sorted_due[$];

    // place the record after every held record with an equal or smaller key
    function automatic void absorb_record(t_in_item item);
        int   pos;
        t_rec rec;
        if (held_set.size() >= MAX_RECORDS) begin
            set_dropped = 1'b1;
        end else begin
            pos = 0;
            while (pos < held_set.size() &&
                   $signed(held_set[pos].key) <= $signed(item.record_key))
                pos++;
            rec.key = item.record_key;
            rec.id  = item.record_id;
            held_set.insert(pos, rec);
        end
        if (item.last_record) begin
            foreach (held_set[i]) begin
                sorted_due.push_back('{sorted_key: held_set[i].key,
                                       sorted_id: held_set[i].id,
                                       last_out: (i == held_set.size() - 1),
                                       overflowed: set_dropped});
            end
            held_set.delete();
            set_dropped = 1'b0;
        end
    endfunction

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            held_set.delete();
            sorted_due.delete();
            set_dropped = 1'b0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (sorted_due.size() == 0) begin
                    $display("%0t: unexpected result expected none actual %p",
                             $time, i_out_item);
                    o_fail_count++;
                end else begin
                    want = sorted_due.pop_front();
                    check_field("sorted_key", want.sorted_key, i_out_item.sorted_key);
                    check_field("sorted_id", want.sorted_id, i_out_item.sorted_id);
                    check_field("last_out", 32'(want.last_out), 32'(i_out_item.last_out));
                    check_field("overflowed", 32'(want.overflowed),
                                32'(i_out_item.overflowed));
                end
            end
            if (i_in_valid && i_in_ready)
                absorb_record(i_in_item);
        end
        o_records_due = sorted_due.size();
    end

endmodule

// ----- dv/record_key_sorter_core_tb.sv -----
module record_key_sorter_core_tb;
    import rks_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP          = 64;
    localparam int RANDOM_ITEMS = 360;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_TOGGLE
    } t_ready_mode;

    typedef enum int {
        KEYS_WIDE,
        KEYS_TIES,
        KEYS_EXTREME,
        KEYS_FALLING
    } t_key_mode;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    int fail_count;
    int records_due;
    int cycle_count = 0;
    int burst_left = 0;
    int random_sent = 0;
    bit sender_idle = 1'b1;

    t_ready_mode ready_mode = READY_ALWAYS;
    int          mode_left = 0;

    record_key_sorter_core #(.MAX_RECORDS(CAP)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    record_key_sorter_core_chk #(.MAX_RECORDS(CAP)) sort_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_in_item     (i_in_item),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_out_item    (o_out_item),
        .o_fail_count  (fail_count),
        .o_records_due (records_due)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: switch stall pattern whenever the mode counter runs out
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode <= t_ready_mode'($urandom_range(0, 3));
            mode_left  <= $urandom_range(20, 120);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            READY_ALWAYS: i_out_ready <= 1'b1;
            READY_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
            default:      i_out_ready <= ~i_out_ready;
        endcase
    end

    // hold the record until accepted, then maybe drop valid for a gap
    task automatic send_record(input logic signed [31:0] key, input logic [31:0] id,
                               input logic last);
        int gap;
        sender_idle = 1'b0;
        i_in_item  <= '{record_key: key, record_id: id, last_record: last};
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                sender_idle = 1'b1;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    function automatic logic signed [31:0] pick_key(t_key_mode mode, int idx);
        case (mode)
            KEYS_WIDE:  return $urandom;
            KEYS_TIES:  return $signed($urandom_range(0, 8)) - 4;
            KEYS_FALLING: return -3 * idx;
            default: begin
                case ($urandom_range(0, 4))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 0;
                    3: return -1;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    initial begin
        logic signed [31:0] edge_keys[5];
        logic signed [31:0] tie_keys[6];
        int set_no;
        int set_size;
        t_key_mode key_mode;

        edge_keys = '{32'sh7fff_ffff, 0, -1, 32'sh8000_0000, 1};
        tie_keys  = '{7, 7, -3, 7, -3, 7};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-record set
        send_record(32'sh8000_0000, 32'hffff_ffff, 1'b1);
        foreach (edge_keys[i])
            send_record(edge_keys[i], 32'(i), (i == 4));
        // equal keys must keep arrival order
        foreach (tie_keys[i])
            send_record(tie_keys[i], 32'h100 + i, (i == 5));
        for (int i = 0; i < 5; i++)
            send_record(100 - 40 * i, 32'h200 + i, (i == 4));
        send_record(32'sh8000_0000, 32'h0, 1'b0);
        send_record(32'sh8000_0000, 32'h1, 1'b1);

        set_no = 0;
        while (random_sent < RANDOM_ITEMS) begin
            // full set, then overflow sets where the last record is dropped too
            case (set_no)
                2:       set_size = CAP;
                5:       set_size = CAP + 3;
                8:       set_size = CAP + 1;
                default: set_size = $urandom_range(1, 12);
            endcase
            key_mode = t_key_mode'($urandom_range(0, 3));
            for (int i = 0; i < set_size; i++)
                send_record(pick_key(key_mode, i), $urandom, (i == set_size - 1));
            random_sent += set_size;
            set_no++;
        end

        if (!sender_idle)
            i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (records_due != 0)
            @(posedge i_clk);
        repeat (CAP) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
